@@ src/digit_frequency_mode_defines.svh @@
// assertion macros for the digit frequency block
// used by the top level only; expects clk and rst in scope
`ifndef DIGIT_FREQUENCY_MODE_DEFINES_SVH
`define DIGIT_FREQUENCY_MODE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DFM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("digit_frequency_mode: check failed");

// next-cycle implication, disabled during reset
`define DFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("digit_frequency_mode: check failed");

`endif

@@ src/dfm_pkg.sv @@
// shared types and constants for the digit frequency block
// no dependencies
`timescale 1ns / 1ps

package dfm_pkg;

  localparam int COUNT_BITS_DEF = 18;
  localparam int NUM_DIGITS     = 10;
  localparam int DIGIT_BITS     = 4;
  localparam int VALUE_BITS     = 32;
  localparam int MAXC_BITS      = 18;
  localparam logic [MAXC_BITS-1:0] MAXC_MAX = '1;

  // floor(n / 10) = (n * RECIP_TEN) >> RECIP_SHIFT for any 32-bit n
  localparam logic [VALUE_BITS-1:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 35;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PEEL,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;   // take a new value into the magnitude register
    logic peel;   // peel one digit and tally it
    logic scan;   // examine one counter for the mode search
    logic emit;   // load the result register and clear the counters
  } cmd_t;

  typedef struct packed {
    logic quot_zero;  // digit being peeled is the most significant one
    logic last;       // current value closes the data set
    logic scan_done;  // mode search is at the final counter
  } status_t;

endpackage

@@ src/dfm_ctrl.sv @@
// controller state machine for the digit frequency block
// depends on dfm_pkg
`timescale 1ns / 1ps

module dfm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  dfm_pkg::status_t status,
  output dfm_pkg::cmd_t    cmd
);

  dfm_pkg::state_t state;
  dfm_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dfm_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = dfm_pkg::ST_PEEL;
      end
      dfm_pkg::ST_PEEL: begin
        if (status.quot_zero) begin
          state_next = status.last ? dfm_pkg::ST_SCAN : dfm_pkg::ST_IDLE;
        end
      end
      dfm_pkg::ST_SCAN: begin
        if (status.scan_done) state_next = dfm_pkg::ST_EMIT;
      end
      dfm_pkg::ST_EMIT: begin
        if (out_free) state_next = dfm_pkg::ST_IDLE;
      end
      default: state_next = dfm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      dfm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      dfm_pkg::ST_PEEL: cmd.peel = 1'b1;
      dfm_pkg::ST_SCAN: cmd.scan = 1'b1;
      dfm_pkg::ST_EMIT: cmd.emit = out_free;
      default: cmd = '0;
    endcase
  end

  // result beat valid; a new result may replace one taken in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

@@ src/dfm_dp.sv @@
// datapath for the digit frequency block: digit peeling, counters, mode search
// depends on dfm_pkg
`timescale 1ns / 1ps

module dfm_dp #(
  parameter int COUNT_BITS = dfm_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dfm_pkg::cmd_t                        cmd,
  output dfm_pkg::status_t                     status,
  input  logic signed [dfm_pkg::VALUE_BITS-1:0] value,
  input  logic                                 last_item,
  output logic [dfm_pkg::NUM_DIGITS-1:0]       digit_mask,
  output logic [dfm_pkg::MAXC_BITS-1:0]        max_count,
  output logic [dfm_pkg::DIGIT_BITS-1:0]       first_digit
);

  localparam int VB = dfm_pkg::VALUE_BITS;
  localparam int ND = dfm_pkg::NUM_DIGITS;
  localparam int DB = dfm_pkg::DIGIT_BITS;
  localparam int QB = 2 * VB - dfm_pkg::RECIP_SHIFT;
  localparam int EXT_BITS = (COUNT_BITS > dfm_pkg::MAXC_BITS) ? COUNT_BITS
                                                               : dfm_pkg::MAXC_BITS;
  localparam logic [DB-1:0] IDX_LAST = DB'(ND - 1);

  logic [VB-1:0]         mag;
  logic                  last_flag;
  logic [2*VB-1:0]       prod;
  logic [QB-1:0]         quot;
  logic [DB-1:0]         q_lo;
  logic [DB-1:0]         rem;
  logic [COUNT_BITS-1:0] counts [ND];
  logic [DB-1:0]         scan_idx;
  logic [COUNT_BITS-1:0] best;
  logic [COUNT_BITS-1:0] scan_cnt;
  logic [DB-1:0]         first;
  logic [ND-1:0]         mask;
  logic [ND-1:0]         idx_bit;
  logic [EXT_BITS-1:0]   best_ext;
  logic [dfm_pkg::MAXC_BITS-1:0] best_sat;

  // divide by ten through the reciprocal; remainder needs only the low nibble
  assign prod = (2*VB)'(mag) * (2*VB)'(dfm_pkg::RECIP_TEN);
  assign quot = prod[2*VB-1:dfm_pkg::RECIP_SHIFT];
  assign q_lo = quot[DB-1:0];
  assign rem  = mag[DB-1:0] - DB'((q_lo << 3) + (q_lo << 1));

  assign status.quot_zero = (quot == '0);
  assign status.last      = last_flag;
  assign status.scan_done = (scan_idx == IDX_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      mag <= '0;
    end else if (cmd.load) begin
      mag <= value[VB-1] ? (~$unsigned(value) + VB'(1)) : $unsigned(value);
    end else if (cmd.peel) begin
      mag <= VB'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) last_flag <= last_item;
  end

  // saturating digit counters
  always_ff @(posedge clk) begin
    for (int d = 0; d < ND; d++) begin
      if (rst || cmd.emit) begin
        counts[d] <= '0;
      end else if (cmd.peel && rem == DB'(d) && counts[d] != '1) begin
        counts[d] <= counts[d] + COUNT_BITS'(1);
      end
    end
  end

  // mode search, one counter per cycle
  assign scan_cnt = counts[scan_idx];
  assign idx_bit  = ND'(1) << scan_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_idx <= '0;
      best     <= '0;
      first    <= '0;
      mask     <= '0;
    end else if (cmd.scan) begin
      scan_idx <= scan_idx + DB'(1);
      if (scan_cnt > best) begin
        best  <= scan_cnt;
        first <= scan_idx;
        mask  <= idx_bit;
      end else if (scan_cnt == best) begin
        mask <= mask | idx_bit;
      end
    end
  end

  assign best_ext = EXT_BITS'(best);
  assign best_sat = (best_ext > EXT_BITS'(dfm_pkg::MAXC_MAX)) ? dfm_pkg::MAXC_MAX
                                                              : best_ext[dfm_pkg::MAXC_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digit_mask  <= mask;
      max_count   <= best_sat;
      first_digit <= first;
    end
  end

endmodule

@@ src/digit_frequency_mode.sv @@
// an accepted beat is worked one digit at a time, D = decimal digits of |value| (1 to 10)
// a last beat adds a scan of the ten digit counters and a load of the result register
// the result beat follows the digit loop and the one-counter-per-cycle scan, and its load
// waits while an earlier result is still held; next input is taken while a result waits
// synchronous active-high rst clears the counters, the state machine and m_tvalid
`timescale 1ns / 1ps
`include "digit_frequency_mode_defines.svh"

module digit_frequency_mode #(
  parameter int COUNT_BITS = dfm_pkg::COUNT_BITS_DEF  // width of each digit counter
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value (signed)
  input  logic        s_tlast,   // last_item
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [9:0] digit_mask, [27:10] max_count, [31:28] first_digit
);

  dfm_pkg::cmd_t    cmd;
  dfm_pkg::status_t status;

  logic [dfm_pkg::NUM_DIGITS-1:0] digit_mask;
  logic [dfm_pkg::MAXC_BITS-1:0]  max_count;
  logic [dfm_pkg::DIGIT_BITS-1:0] first_digit;

  // sequencer: accept, digit loop, scan, result hand-off
  dfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // magnitude register, divide-by-ten step, ten counters, result register
  dfm_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .value       ($signed(s_tdata)),
    .last_item   (s_tlast),
    .digit_mask  (digit_mask),
    .max_count   (max_count),
    .first_digit (first_digit)
  );

  assign m_tdata = {first_digit, max_count, digit_mask};

  // one value is worked at a time: an accepted beat blocks the next cycle
  `DFM_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // the reported digit is a real decimal digit
  `DFM_ASSERT_NOW(a_first_digit_range, m_tvalid, m_tdata[31:28] <= 4'd9)
  // at least one digit always holds the highest count
  `DFM_ASSERT_NOW(a_mask_nonempty, m_tvalid, m_tdata[9:0] != 10'd0)

endmodule

@@ verif/mode_check_pkg.sv @@
// result layout and scoreboard for the digit frequency testbench
// depends on dfm_pkg for digit counts and field widths
`timescale 1ns / 1ps

package mode_check_pkg;

  import dfm_pkg::*;

  // one result beat, last field in the lowest bits
  typedef struct packed {
    logic [DIGIT_BITS-1:0] first_digit;
    logic [MAXC_BITS-1:0]  max_count;
    logic [NUM_DIGITS-1:0] digit_mask;
  } mode_result_t;

  class mode_scoreboard;
    bit [COUNT_BITS_DEF-1:0] digit_tally [NUM_DIGITS];
    mode_result_t            awaited_q [$];
    int                      errors;

    // tally the digits of one accepted value; a closing value yields a result
    function void note_value(logic [VALUE_BITS-1:0] value, logic last);
      logic [VALUE_BITS-1:0] mag;
      longint unsigned       best;
      int unsigned           first;
      mode_result_t          want;
      // two's complement magnitude; the most negative value maps to 2^31
      mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
      // a zero magnitude still counts one zero digit
      do begin
        if (digit_tally[mag % 10] != '1) digit_tally[mag % 10]++;
        mag = mag / 10;
      end while (mag != 0);
      if (!last) return;
      best  = 0;
      first = 0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (digit_tally[d] > best) begin
          best  = digit_tally[d];
          first = d;
        end
      end
      want.digit_mask = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (digit_tally[d] == best) want.digit_mask[d] = 1'b1;
      end
      want.max_count   = (best > MAXC_MAX) ? MAXC_MAX : MAXC_BITS'(best);
      want.first_digit = DIGIT_BITS'(first);
      awaited_q.push_back(want);
      foreach (digit_tally[d]) digit_tally[d] = '0;
    endfunction

    // compare one result beat with the oldest awaited result
    function void check_result(logic [31:0] beat);
      mode_result_t got;
      mode_result_t want;
      got = beat;
      if (awaited_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, beat);
        errors++;
        return;
      end
      want = awaited_q.pop_front();
      if (got.digit_mask !== want.digit_mask) begin
        $display("%0t: digit_mask expected %b got %b", $time, want.digit_mask,
                 got.digit_mask);
        errors++;
      end
      if (got.max_count !== want.max_count) begin
        $display("%0t: max_count expected %0d got %0d", $time, want.max_count,
                 got.max_count);
        errors++;
      end
      if (got.first_digit !== want.first_digit) begin
        $display("%0t: first_digit expected %0d got %0d", $time, want.first_digit,
                 got.first_digit);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited_q.size();
    endfunction
  endclass

endpackage

@@ verif/tb_top.sv @@
// top-level testbench for digit_frequency_mode: streams signed values in frames,
// predicts the most frequent digit of each frame and checks every result beat
// depends on dfm_pkg, mode_check_pkg and the digit_frequency_mode rtl
`timescale 1ns / 1ps

module tb_top;

  import dfm_pkg::*;
  import mode_check_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int          RANDOM_BEATS = 800;
  localparam int          CALM_BEATS   = 100;    // tail of the run without idling
  localparam int          RUN_BEATS    = 20;     // 10 ones per beat in one long frame
  localparam int          HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int          SETTLE       = 40;     // worst-case result latency with margin

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;

  mode_scoreboard sb = new;
  bit             calm;           // no idling on either side
  bit             sink_hold_req;  // receiver holds off, cleared by the receiver
  int unsigned    cycle_count;

  digit_frequency_mode #(.COUNT_BITS(COUNT_BITS_DEF)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAIL digit_frequency_mode");
      $finish;
    end
  end

  // both handshakes are observed at the rising edge
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_value(s_tdata, s_tlast);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      if (sink_hold_req) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        sink_hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        @(negedge clk) m_tready <= 1'b1;
        repeat ($urandom_range(0, 40)) @(negedge clk);
      end
    end
  end

  // offer one beat and wait for its handshake; valid stays up for a following beat
  task automatic send_beat(input logic [31:0] value, input logic last);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle_sender(input int cycles);
    @(negedge clk) s_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // sender pause until every frame result has come back
  task automatic drain_results();
    @(negedge clk) s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] rep;
    rep = 32'($urandom_range(1, 9)) * 32'd111111111;
    case ($urandom_range(0, 7))
      0: return 32'($urandom_range(0, 9));
      1: return 32'($urandom_range(0, 999));
      2: return 32'(0) - 32'($urandom_range(0, 99999));
      3: begin
        case ($urandom_range(0, 6))
          0: return 32'h0000_0000;
          1: return 32'h8000_0000;
          2: return 32'h7FFF_FFFF;
          3: return 32'hFFFF_FFFF;
          4: return 32'h8000_0001;
          5: return 32'd1000000000;
          default: return 32'd999999999;
        endcase
      end
      4: return $urandom_range(0, 1) ? rep : (~rep + 1'b1);  // all digits equal
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int sent;
    int frame_len;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    calm     = 1'b0;
    sink_hold_req = 1'b0;
    cycle_count   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: zero, extremes of the value, ties, repeated digits, bit patterns
    send_beat(32'h0000_0000, 1'b1);
    send_beat(32'h8000_0000, 1'b1);
    send_beat(32'h7FFF_FFFF, 1'b1);
    send_beat(32'hFFFF_FFFF, 1'b1);
    send_beat(32'h8000_0001, 1'b1);
    send_beat(32'd9, 1'b0);
    send_beat(32'd1234567890, 1'b0);
    send_beat(32'(0) - 32'd987654321, 1'b1);
    send_beat(32'd1000000000, 1'b1);
    send_beat(32'd5, 1'b0);
    send_beat(32'd5, 1'b1);
    send_beat(32'hAAAA_AAAA, 1'b0);
    send_beat(32'h5555_5555, 1'b1);
    send_beat(32'd10, 1'b1);
    send_beat(32'd99, 1'b1);
    send_beat(32'(0) - 32'd10, 1'b0);
    send_beat(32'h0000_0000, 1'b1);
    drain_results();

    // one long frame of 1111111111 beats, back to back
    for (int i = 0; i < RUN_BEATS; i++) send_beat(32'd1111111111, 1'b0);
    send_beat(32'd1111111111, 1'b1);
    drain_results();

    // receiver holds off while short frames keep coming, so the input backs up
    sink_hold_req = 1'b1;
    sent = 0;
    while (sink_hold_req) begin
      send_beat(pick_value(), (sent % 3) == 2);
      sent++;
    end
    while ((sent % 3) != 0) begin
      send_beat(pick_value(), (sent % 3) == 2);
      sent++;
    end

    // random frames, mostly short
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      for (int i = 0; i < frame_len; i++) begin
        calm = (sent >= RANDOM_BEATS - CALM_BEATS);
        if (!calm && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 18));
        send_beat(pick_value(), i == frame_len - 1);
        sent++;
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS digit_frequency_mode");
    end else begin
      $display("FAIL digit_frequency_mode");
    end
    $finish;
  end

endmodule
